@@ rtl/cpbc_pkg.sv @@
// ----------------------------------------------------------------------------
// cpbc_pkg: shared types and constants of the camera pixel converter
// Format codes, per-stage word structs and the BT.601 coefficients used by
// the YUV lanes, plus the shift-and-clamp helper that ends each channel.
// ----------------------------------------------------------------------------
package cpbc_pkg;

    // input layout codes held in the pixel_format register
    typedef enum logic [2:0] {
        FMT_YUYV  = 3'd0,
        FMT_UYVY  = 3'd1,
        FMT_NV12  = 3'd2,
        FMT_RGB24 = 3'd3,
        FMT_BGR24 = 3'd4
    } fmt_t;

    // register index decoded from paddr
    localparam logic REG_PIXEL_FORMAT = 1'b0;

    // arithmetic width of products and sums (signed)
    localparam int SUM_W = 20;

    // BT.601 integer coefficients
    localparam logic signed [SUM_W-1:0] K_Y     = 20'sd298;
    localparam logic signed [SUM_W-1:0] K_RV    = 20'sd409;
    localparam logic signed [SUM_W-1:0] K_GU    = 20'sd100;
    localparam logic signed [SUM_W-1:0] K_GV    = 20'sd208;
    localparam logic signed [SUM_W-1:0] K_BU    = 20'sd516;
    localparam logic signed [SUM_W-1:0] K_ROUND = 20'sd128;
    localparam logic signed [9:0]       Y_OFS   = 10'sd16;
    localparam logic signed [9:0]       C_OFS   = 10'sd128;
    localparam logic [7:0]              ALPHA   = 8'hFF;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pix_t;

    // control that rides along with an item through the pipe
    typedef struct packed {
        logic two;   // item gives two pixels
        logic rgb;   // direct pixel, no conversion
        logic fend;  // frame end flag of the item
        pix_t byp;   // reordered bytes for RGB24 / BGR24
    } ctrl_t;

    // unpacked stage word
    typedef struct packed {
        ctrl_t      ctrl;
        logic [7:0] y0;
        logic [7:0] y1;
        logic [7:0] u;
        logic [7:0] v;
    } s1_t;

    // floor(sum / 256) clamped to 0..255
    function automatic logic [7:0] shift_clamp(input logic signed [SUM_W-1:0] sum);
        logic [7:0] res;
        if (sum[SUM_W-1]) begin
            res = 8'd0;
        end else if (|sum[SUM_W-2:16]) begin
            res = 8'hFF;
        end else begin
            res = sum[15:8];
        end
        return res;
    endfunction

endpackage

@@ rtl/cpbc_unpack.sv @@
// ----------------------------------------------------------------------------
// cpbc_unpack: format decode stage
// Picks luma, chroma and direct bytes out of the input word according to the
// pixel format and registers them as the first pipeline stage.
// ----------------------------------------------------------------------------
module cpbc_unpack (
    input  logic             aclk,
    input  logic             en,
    input  logic [2:0]       pixel_format,
    input  logic [7:0]       byte0,
    input  logic [7:0]       byte1,
    input  logic [7:0]       byte2,
    input  logic [7:0]       byte3,
    input  logic             frame_end_in,
    output logic             known,        // format code is a valid layout
    output cpbc_pkg::s1_t    s1_q
);

    cpbc_pkg::s1_t s1_next;
    cpbc_pkg::s1_t s1_reg;

    // byte selection per layout
    always_comb begin
        s1_next           = '0;
        s1_next.ctrl.fend = frame_end_in;
        known             = 1'b1;
        unique case (cpbc_pkg::fmt_t'(pixel_format))
            cpbc_pkg::FMT_YUYV: begin
                s1_next.ctrl.two = 1'b1;
                s1_next.y0       = byte0;
                s1_next.u        = byte1;
                s1_next.y1       = byte2;
                s1_next.v        = byte3;
            end
            cpbc_pkg::FMT_UYVY: begin
                s1_next.ctrl.two = 1'b1;
                s1_next.u        = byte0;
                s1_next.y0       = byte1;
                s1_next.v        = byte2;
                s1_next.y1       = byte3;
            end
            cpbc_pkg::FMT_NV12: begin
                s1_next.y0 = byte0;
                s1_next.u  = byte1;
                s1_next.v  = byte2;
                s1_next.y1 = byte0;
            end
            cpbc_pkg::FMT_RGB24: begin
                s1_next.ctrl.rgb       = 1'b1;
                s1_next.ctrl.byp.red   = byte0;
                s1_next.ctrl.byp.green = byte1;
                s1_next.ctrl.byp.blue  = byte2;
            end
            cpbc_pkg::FMT_BGR24: begin
                s1_next.ctrl.rgb       = 1'b1;
                s1_next.ctrl.byp.blue  = byte0;
                s1_next.ctrl.byp.green = byte1;
                s1_next.ctrl.byp.red   = byte2;
            end
            default: begin
                known = 1'b0;
            end
        endcase
    end

    // stage register (payload only)
    always_ff @(posedge aclk) begin
        if (en) begin
            s1_reg <= s1_next;
        end
    end

    assign s1_q = s1_reg;

endmodule

@@ rtl/cpbc_yuv_lane.sv @@
// ----------------------------------------------------------------------------
// cpbc_yuv_lane: one BT.601 YUV to RGB lane
// Stage A registers the five coefficient products, stage B the three
// rounded channel sums; the shift and clamp follow combinationally.
// ----------------------------------------------------------------------------
module cpbc_yuv_lane (
    input  logic             aclk,
    input  logic             en,
    input  logic [7:0]       y_i,
    input  logic [7:0]       u_i,
    input  logic [7:0]       v_i,
    output cpbc_pkg::pix_t   pix_o
);

    localparam int W = cpbc_pkg::SUM_W;

    logic signed [9:0]   c_val;
    logic signed [9:0]   d_val;
    logic signed [9:0]   e_val;

    logic signed [W-1:0] py_next, prv_next, pgu_next, pgv_next, pbu_next;
    logic signed [W-1:0] py_reg, prv_reg, pgu_reg, pgv_reg, pbu_reg;
    logic signed [W-1:0] sr_next, sg_next, sb_next;
    logic signed [W-1:0] sr_reg, sg_reg, sb_reg;

    // offsets
    assign c_val = signed'({2'b00, y_i}) - cpbc_pkg::Y_OFS;
    assign d_val = signed'({2'b00, u_i}) - cpbc_pkg::C_OFS;
    assign e_val = signed'({2'b00, v_i}) - cpbc_pkg::C_OFS;

    // stage A: products
    assign py_next  = W'(c_val) * cpbc_pkg::K_Y;
    assign prv_next = W'(e_val) * cpbc_pkg::K_RV;
    assign pgu_next = W'(d_val) * cpbc_pkg::K_GU;
    assign pgv_next = W'(e_val) * cpbc_pkg::K_GV;
    assign pbu_next = W'(d_val) * cpbc_pkg::K_BU;

    always_ff @(posedge aclk) begin
        if (en) begin
            py_reg  <= py_next;
            prv_reg <= prv_next;
            pgu_reg <= pgu_next;
            pgv_reg <= pgv_next;
            pbu_reg <= pbu_next;
        end
    end

    // stage B: rounded sums
    assign sr_next = py_reg + prv_reg + cpbc_pkg::K_ROUND;
    assign sg_next = py_reg - pgu_reg - pgv_reg + cpbc_pkg::K_ROUND;
    assign sb_next = py_reg + pbu_reg + cpbc_pkg::K_ROUND;

    always_ff @(posedge aclk) begin
        if (en) begin
            sr_reg <= sr_next;
            sg_reg <= sg_next;
            sb_reg <= sb_next;
        end
    end

    // floor shift and clamp
    assign pix_o.red   = cpbc_pkg::shift_clamp(sr_reg);
    assign pix_o.green = cpbc_pkg::shift_clamp(sg_reg);
    assign pix_o.blue  = cpbc_pkg::shift_clamp(sb_reg);

endmodule

@@ rtl/cpbc_out_stage.sv @@
// ----------------------------------------------------------------------------
// cpbc_out_stage: output register and pixel serializer
// Holds one finished item (one or two pixels) and hands its pixels out in
// order; tells the pipe when it may advance.
// ----------------------------------------------------------------------------
module cpbc_out_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    input  cpbc_pkg::ctrl_t  in_ctrl,
    input  cpbc_pkg::pix_t   lane0,
    input  cpbc_pkg::pix_t   lane1,
    output logic             advance,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [31:0]      m_tdata,
    output logic             m_tuser,
    output logic             m_tlast
);

    logic            valid_reg;
    logic            phase_reg;
    cpbc_pkg::ctrl_t ctrl_reg;
    cpbc_pkg::pix_t  p0_reg;
    cpbc_pkg::pix_t  p1_reg;
    cpbc_pkg::pix_t  pix;
    logic            take;
    logic            last_beat;

    assign take      = valid_reg && m_tready;
    assign last_beat = !ctrl_reg.two || phase_reg;
    assign advance   = !valid_reg || (take && last_beat);

    // control: valid and beat phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
            phase_reg <= 1'b0;
        end else if (take) begin
            phase_reg <= 1'b1;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (advance) begin
            ctrl_reg <= in_ctrl;
            p0_reg   <= lane0;
            p1_reg   <= lane1;
        end
    end

    // pixel select: direct bytes, or lane by beat
    always_comb begin
        if (ctrl_reg.rgb) begin
            pix = ctrl_reg.byp;
        end else if (ctrl_reg.two && phase_reg) begin
            pix = p1_reg;
        end else begin
            pix = p0_reg;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {cpbc_pkg::ALPHA, pix.red, pix.green, pix.blue};
    assign m_tuser  = last_beat;
    assign m_tlast  = last_beat && ctrl_reg.fend;

endmodule

@@ rtl/camera_pixel_to_bgra_converter.sv @@
// ----------------------------------------------------------------------------
// camera_pixel_to_bgra_converter: camera pixel words to BGRA pixels
// Decodes YUYV, UYVY, NV12, RGB24 and BGR24 input words and gives BGRA
// pixels with alpha 255, using the BT.601 integer conversion for YUV.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one input word per beat, bytes 0..3 in s_tdata, frame end
//   on s_tlast. m_ channel: one BGRA pixel per beat, last pixel of the
//   input word on m_tuser, frame end (last pixel only) on m_tlast.
//   pixel_format is set over the APB port at address 0 while idle; words
//   with an unknown format code are taken and dropped.
// Pipeline: a word's first pixel passes the decode register (loaded at
//   the edge that takes the word), then the product, sum and output
//   registers before it shows on m_tvalid.
// Throughput: one word per cycle for NV12, RGB24 and BGR24 while m_tready
//   stays high; YUYV and UYVY words give two pixels each, and the one-pixel
//   output port takes no new word until the second pixel is taken.
// Reset: aresetn (synchronous, low) empties the pipe and sets the format
//   to YUYV.
// Stall: when m_tready is low with a pixel waiting the whole pipe holds,
//   s_tready drops, and nothing is lost or repeated; the output register
//   keeps its pixel.
// ----------------------------------------------------------------------------
module camera_pixel_to_bgra_converter (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // byte0, byte1, byte2, byte3
    input  logic        s_tlast,   // frame_end_in
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // blue, green, red, alpha
    output logic        m_tuser,   // last_of_group
    output logic        m_tlast,   // frame_end_out
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic            advance;
    logic            known;
    logic            cfg_wr;
    logic [2:0]      fmt_reg;
    logic            v1_reg, va_reg, vb_reg;
    cpbc_pkg::s1_t   s1;
    cpbc_pkg::ctrl_t ctrl_a_reg, ctrl_b_reg;
    cpbc_pkg::pix_t  lane0, lane1;

    // configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg <= cpbc_pkg::FMT_YUYV;
        end else if (cfg_wr && (paddr[2] == cpbc_pkg::REG_PIXEL_FORMAT)) begin
            fmt_reg <= pwdata[2:0];
        end
    end

    assign prdata = (paddr[2] == cpbc_pkg::REG_PIXEL_FORMAT) ? {29'd0, fmt_reg} : 32'd0;

    // whole pipe moves when the output stage can take a word
    assign s_tready = advance;

    cpbc_unpack u_unpack (
        .aclk         (aclk),
        .en           (advance),
        .pixel_format (fmt_reg),
        .byte0        (s_tdata[7:0]),
        .byte1        (s_tdata[15:8]),
        .byte2        (s_tdata[23:16]),
        .byte3        (s_tdata[31:24]),
        .frame_end_in (s_tlast),
        .known        (known),
        .s1_q         (s1)
    );

    cpbc_yuv_lane u_lane0 (
        .aclk  (aclk),
        .en    (advance),
        .y_i   (s1.y0),
        .u_i   (s1.u),
        .v_i   (s1.v),
        .pix_o (lane0)
    );

    cpbc_yuv_lane u_lane1 (
        .aclk  (aclk),
        .en    (advance),
        .y_i   (s1.y1),
        .u_i   (s1.u),
        .v_i   (s1.v),
        .pix_o (lane1)
    );

    // valid bits alongside the lane stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else if (advance) begin
            v1_reg <= s_tvalid && known;
            va_reg <= v1_reg;
            vb_reg <= va_reg;
        end
    end

    // control word alongside the lane stages
    always_ff @(posedge aclk) begin
        if (advance) begin
            ctrl_a_reg <= s1.ctrl;
            ctrl_b_reg <= ctrl_a_reg;
        end
    end

    cpbc_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (vb_reg),
        .in_ctrl  (ctrl_b_reg),
        .lane0    (lane0),
        .lane1    (lane1),
        .advance  (advance),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

@@ rtl/cpbc_checker.sv @@
// ----------------------------------------------------------------------------
// cpbc_checker: port-level checks for the pixel converter
// Watches the top level's ports only; attached by bind below.
// ----------------------------------------------------------------------------
module cpbc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // a stalled output word stays put
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
            && $stable(m_tuser) && $stable(m_tlast))
        else $error("output word changed while stalled");

    // every pixel is opaque
    a_alpha: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[31:24] == 8'hFF)
        else $error("alpha is not 255");

    // frame end only on the last pixel of a word
    a_fend_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser)
        else $error("frame end on a first pixel");

    // a first pixel is always followed by the second of its pair
    a_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tuser |=> m_tvalid && m_tuser)
        else $error("second pixel of a pair missing");

    // an empty output register never blocks the input
    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with the output empty");

endmodule

bind camera_pixel_to_bgra_converter cpbc_checker u_cpbc_checker (.*);

@@ tb/cpbc_tb_pkg.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cpbc_tb_pkg: pixel scoreboard for the camera pixel converter bench
// Predicts the BGRA pixels of each accepted input word from its own copy of
// the pixel_format register, and checks output pixels in order against them.
// ----------------------------------------------------------------------------
package cpbc_tb_pkg;

    // one predicted output pixel
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] alpha;
        logic       group_last;
        logic       frame_end;
    } bgra_pixel_t;

    class pixel_scoreboard;

        bgra_pixel_t pending_pixels[$];
        logic [2:0]  pixel_fmt = cpbc_pkg::FMT_YUYV;
        int          errors = 0;

        // mirror a register write; the word index sits in addr[2]
        function void write_reg(logic [2:0] addr, logic [31:0] value);
            if (addr[2] == cpbc_pkg::REG_PIXEL_FORMAT) begin
                pixel_fmt = value[2:0];
            end
        endfunction

        function int pending();
            return pending_pixels.size();
        endfunction

        function logic [7:0] clamp8(int x);
            if (x < 0) begin
                return 8'd0;
            end
            if (x > 255) begin
                return 8'd255;
            end
            return x[7:0];
        endfunction

        function bgra_pixel_t make_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r,
                                         logic grp_last, logic fend);
            bgra_pixel_t p;
            p.blue       = b;
            p.green      = g;
            p.red        = r;
            p.alpha      = cpbc_pkg::ALPHA;
            p.group_last = grp_last;
            p.frame_end  = fend;
            return p;
        endfunction

        // BT.601 integer conversion; >>> on int floors toward minus infinity
        function bgra_pixel_t yuv_to_bgra(logic [7:0] y, logic [7:0] u, logic [7:0] v,
                                          logic grp_last, logic fend);
            int c;
            int d;
            int e;
            c = int'(y) - 16;
            d = int'(u) - 128;
            e = int'(v) - 128;
            return make_pixel(clamp8((298 * c + 516 * d + 128) >>> 8),
                              clamp8((298 * c - 100 * d - 208 * e + 128) >>> 8),
                              clamp8((298 * c + 409 * e + 128) >>> 8),
                              grp_last, fend);
        endfunction

        // queue the pixels an accepted input word must give
        function void note_word(logic [31:0] data, logic fend);
            logic [7:0] b0;
            logic [7:0] b1;
            logic [7:0] b2;
            logic [7:0] b3;
            b0 = data[7:0];
            b1 = data[15:8];
            b2 = data[23:16];
            b3 = data[31:24];
            unique case (pixel_fmt)
                cpbc_pkg::FMT_YUYV: begin
                    pending_pixels.push_back(yuv_to_bgra(b0, b1, b3, 1'b0, 1'b0));
                    pending_pixels.push_back(yuv_to_bgra(b2, b1, b3, 1'b1, fend));
                end
                cpbc_pkg::FMT_UYVY: begin
                    pending_pixels.push_back(yuv_to_bgra(b1, b0, b2, 1'b0, 1'b0));
                    pending_pixels.push_back(yuv_to_bgra(b3, b0, b2, 1'b1, fend));
                end
                cpbc_pkg::FMT_NV12: begin
                    pending_pixels.push_back(yuv_to_bgra(b0, b1, b2, 1'b1, fend));
                end
                cpbc_pkg::FMT_RGB24: begin
                    pending_pixels.push_back(make_pixel(b2, b1, b0, 1'b1, fend));
                end
                cpbc_pkg::FMT_BGR24: begin
                    pending_pixels.push_back(make_pixel(b0, b1, b2, 1'b1, fend));
                end
                default: begin
                    // unknown code: word is dropped, frame end included
                end
            endcase
        endfunction

        // compare one output pixel with the oldest prediction
        function void check_pixel(logic [31:0] data, logic user, logic last);
            bgra_pixel_t want;
            if (pending_pixels.size() == 0) begin
                $error("pixel with nothing predicted: tdata=%h tuser=%b tlast=%b",
                       data, user, last);
                errors++;
                return;
            end
            want = pending_pixels.pop_front();
            if (data[7:0] !== want.blue) begin
                $error("blue: expected %0d, got %0d", want.blue, data[7:0]);
                errors++;
            end
            if (data[15:8] !== want.green) begin
                $error("green: expected %0d, got %0d", want.green, data[15:8]);
                errors++;
            end
            if (data[23:16] !== want.red) begin
                $error("red: expected %0d, got %0d", want.red, data[23:16]);
                errors++;
            end
            if (data[31:24] !== want.alpha) begin
                $error("alpha: expected %0d, got %0d", want.alpha, data[31:24]);
                errors++;
            end
            if (user !== want.group_last) begin
                $error("last_of_group: expected %0d, got %0d", want.group_last, user);
                errors++;
            end
            if (last !== want.frame_end) begin
                $error("frame_end_out: expected %0d, got %0d", want.frame_end, last);
                errors++;
            end
        endfunction

    endclass

endpackage

@@ tb/camera_pixel_to_bgra_converter_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// camera_pixel_to_bgra_converter_test: bench for the camera pixel converter
// Runs corner words through every format (reset format first), unknown
// format codes and a write to an unmapped address, then random words in
// phases (each format in turn, then random ones, one on an unknown code)
// with random input gaps and output stalls; the scoreboard checks every pixel.
// ----------------------------------------------------------------------------
module camera_pixel_to_bgra_converter_test;

    localparam logic [2:0]       ADDR_PIXEL_FORMAT = 3'd0;
    localparam logic [2:0]       ADDR_UNMAPPED     = 3'd4;
    localparam int               FMT_CODE_MAX      = 7;
    localparam int               WORDS_PER_PHASE   = 48;
    localparam int               NUM_PHASES        = 16;
    localparam int               DROP_PHASE        = 12;
    localparam int               PIPE_FLUSH        = 8;
    // zero, all ones, and alternating extremes that drive every clamp
    localparam logic [3:0][31:0] CORNER_WORDS      = {32'hFF00_FF00, 32'h00FF_00FF,
                                                      32'hFFFF_FFFF, 32'h0000_0000};

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // byte0, byte1, byte2, byte3
    logic        s_tlast;   // frame_end_in
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // blue, green, red, alpha
    logic        m_tuser;   // last_of_group
    logic        m_tlast;   // frame_end_out
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    logic        idle_on;

    cpbc_tb_pkg::pixel_scoreboard sb = new();

    camera_pixel_to_bgra_converter dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #4_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // watch both handshakes; values sampled are the ones before the edge
    always @(posedge aclk) begin
        if (aresetn === 1'b1) begin
            if (s_tvalid && s_tready === 1'b1) begin
                sb.note_word(s_tdata, s_tlast);
            end
            if (m_tvalid === 1'b1 && m_tready) begin
                sb.check_pixel(m_tdata, m_tuser, m_tlast);
            end
        end
    end

    // output back-pressure
    always @(posedge aclk) begin
        m_tready <= !(idle_on && $urandom_range(0, 99) < 8);
    end

    // one input word, with an optional random gap ahead of it
    task automatic send_word(input logic [31:0] data, input logic fend);
        while (idle_on && $urandom_range(0, 99) < 8) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= fend;
        do @(posedge aclk); while (s_tready !== 1'b1);
    endtask

    // APB write: setup cycle, then access cycle; then read the value back
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        logic [31:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_reg(addr, value);
        want = (addr[2] == cpbc_pkg::REG_PIXEL_FORMAT) ? {29'd0, sb.pixel_fmt} : 32'd0;
        @(posedge aclk);
        if (prdata !== want) begin
            $error("prdata: expected %0d, got %0d", want, prdata);
            sb.errors++;
        end
    endtask

    // stop input, let every predicted pixel out, then flush the pipe
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (PIPE_FLUSH) @(posedge aclk);
    endtask

    initial begin
        int fmt_sel;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        idle_on  <= 1'b1;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // corner words in every format; the first pass runs on the reset format
        for (int f = cpbc_pkg::FMT_YUYV; f <= cpbc_pkg::FMT_BGR24; f++) begin
            if (f != cpbc_pkg::FMT_YUYV) begin
                write_reg(ADDR_PIXEL_FORMAT, 32'(f));
            end
            for (int i = 0; i < 4; i++) begin
                send_word(CORNER_WORDS[i], i[0]);
            end
            wait_idle();
        end

        // unknown codes: words are taken and give nothing
        for (int f = cpbc_pkg::FMT_BGR24 + 1; f <= FMT_CODE_MAX; f++) begin
            write_reg(ADDR_PIXEL_FORMAT, 32'(f));
            send_word($urandom(), 1'b1);
            send_word($urandom(), 1'b0);
            wait_idle();
        end

        // a write past the register list must leave the format alone
        write_reg(ADDR_UNMAPPED, 32'(cpbc_pkg::FMT_NV12));
        send_word($urandom(), 1'b1);
        send_word($urandom(), 1'b0);
        wait_idle();

        // random phases; two of them run with no gaps on either side
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph == DROP_PHASE) begin
                fmt_sel = $urandom_range(cpbc_pkg::FMT_BGR24 + 1, FMT_CODE_MAX);
            end else if (ph <= cpbc_pkg::FMT_BGR24) begin
                fmt_sel = ph;
            end else begin
                fmt_sel = $urandom_range(cpbc_pkg::FMT_YUYV, cpbc_pkg::FMT_BGR24);
            end
            idle_on <= !(ph == 6 || ph == 7);
            write_reg(ADDR_PIXEL_FORMAT, 32'(fmt_sel));
            repeat ((ph == DROP_PHASE) ? 10 : WORDS_PER_PHASE) begin
                send_word($urandom(), $urandom_range(0, 7) == 0);
            end
            wait_idle();
        end

        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/cpbc_pkg.sv
rtl/cpbc_unpack.sv
rtl/cpbc_yuv_lane.sv
rtl/cpbc_out_stage.sv
rtl/camera_pixel_to_bgra_converter.sv
rtl/cpbc_checker.sv
tb/cpbc_tb_pkg.sv
tb/camera_pixel_to_bgra_converter_test.sv
